### design/todclk_pkg.sv
// Package for the time-of-day clock: the time record type, the counter limits
// and the seven-segment tables with their digit-split helpers.
// No dependencies.
package todclk_pkg;

   typedef struct packed {
      logic [4:0] hours;
      logic [5:0] minutes;
      logic [5:0] seconds;
   } time_type;

   localparam logic [6:0] SEC_LIMIT  = 7'd60;
   localparam logic [6:0] MIN_LIMIT  = 7'd60;
   localparam logic [5:0] HOUR_LIMIT = 6'd24;

   // Active-low segment bytes; bit 7 of the first byte is the colon and
   // bit 0 of the second byte is the dot.
   localparam logic [7:0] COLON_BIT = 8'h80;
   localparam logic [7:0] DOT_BIT   = 8'h01;

   localparam logic [7:0] TENS_SEG_A [10] = '{
      8'h8F, 8'hEF, 8'hCF, 8'hCF, 8'hAF, 8'h9F, 8'h9F, 8'hCF, 8'h8F, 8'h8F};
   localparam logic [7:0] TENS_SEG_B [10] = '{
      8'h1F, 8'hDF, 8'h2F, 8'h8F, 8'hCF, 8'h8F, 8'h0F, 8'hDF, 8'h0F, 8'h8F};
   localparam logic [7:0] ONES_SEG_A [10] = '{
      8'hF8, 8'hFE, 8'hF4, 8'hF4, 8'hF2, 8'hF1, 8'hF1, 8'hFC, 8'hF0, 8'hF0};
   localparam logic [7:0] ONES_SEG_B [10] = '{
      8'hF1, 8'hFD, 8'hF3, 8'hF9, 8'hFD, 8'hF9, 8'hF1, 8'hFD, 8'hF1, 8'hF9};

   // Tens digit of a value below 64 by a short compare chain.
   function automatic logic [3:0] tens_digit(input logic [5:0] v);
      logic [3:0] t;
      if (v >= 6'd60)      t = 4'd6;
      else if (v >= 6'd50) t = 4'd5;
      else if (v >= 6'd40) t = 4'd4;
      else if (v >= 6'd30) t = 4'd3;
      else if (v >= 6'd20) t = 4'd2;
      else if (v >= 6'd10) t = 4'd1;
      else                 t = 4'd0;
      return t;
   endfunction

   // Ones digit: the value less ten times its tens digit.
   function automatic logic [3:0] ones_digit(input logic [5:0] v, input logic [3:0] t);
      logic [6:0] t10;
      t10 = 7'({t, 3'b000}) + 7'({t, 1'b0});
      return 4'(7'(v) - t10);
   endfunction

endpackage

### design/todclk_counter.sv
// Hours, minutes and seconds counters with the one-second advance logic.
// Depends on todclk_pkg.
module todclk_counter import todclk_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     step,       // apply the item held in the input register
   input  logic     load,       // the item is a load, otherwise a tick
   input  time_type load_time,
   output time_type next_time,  // time after a tick
   output logic     chime,      // the tick rolled minutes into a new hour
   output time_type cur_time
);

   time_type time_ff, time_in;
   logic [6:0] sec_inc, min_inc;
   logic [5:0] hour_inc;
   logic       sec_wrap;

   // Counts at or above their limit after the increment wrap to zero, which
   // also covers out-of-range loads.
   always_comb begin
      sec_inc  = 7'(time_ff.seconds) + 7'd1;
      sec_wrap = (sec_inc >= SEC_LIMIT);
      min_inc  = 7'(time_ff.minutes) + 7'(sec_wrap);
      chime    = (min_inc >= MIN_LIMIT);
      hour_inc = 6'(time_ff.hours) + 6'(chime);

      next_time.seconds = sec_wrap ? 6'd0 : sec_inc[5:0];
      next_time.minutes = chime ? 6'd0 : min_inc[5:0];
      next_time.hours   = (hour_inc >= HOUR_LIMIT) ? 5'd0 : hour_inc[4:0];
   end

   always_comb begin
      time_in = time_ff;
      if (step) begin
         time_in = load ? load_time : next_time;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff <= '0;
      end else begin
         time_ff <= time_in;
      end
   end

   assign cur_time = time_ff;

endmodule

### design/todclk_encoder.sv
// Seven-segment encoder for one two-digit pair with optional colon and dot.
// Depends on todclk_pkg for the segment tables and digit helpers.
module todclk_encoder import todclk_pkg::*; (
   input  logic [5:0] value,
   input  logic       has_colon,
   input  logic       has_dot,
   input  logic       dots_enable,
   output logic [7:0] seg_a,
   output logic [7:0] seg_b
);

   logic [3:0] tens, ones;
   logic [7:0] raw_a, raw_b;

   // Active low: a segment lit by either digit is a zero in its own table,
   // so merging the pair is an AND of the entries.
   always_comb begin
      tens  = tens_digit(value);
      ones  = ones_digit(value, tens);
      raw_a = TENS_SEG_A[tens] & ONES_SEG_A[ones];
      raw_b = TENS_SEG_B[tens] & ONES_SEG_B[ones];

      seg_a = raw_a;
      if (has_colon) begin
         seg_a = dots_enable ? (raw_a & ~COLON_BIT) : (raw_a | COLON_BIT);
      end
      seg_b = raw_b;
      if (has_dot) begin
         seg_b = dots_enable ? (raw_b & ~DOT_BIT) : (raw_b | DOT_BIT);
      end
   end

endmodule

### design/time_of_day_seven_segment_clock.sv
// Time-of-day clock with seven-segment frame output; top level.
// Depends on todclk_pkg, todclk_counter and todclk_encoder.

// The block keeps hours, minutes and seconds. Each request beat carries a mode
// in tuser: mode 0 loads the time from tdata and produces no response, mode 1
// is a one-second tick that advances the time and produces one response beat.
// Seconds and minutes wrap at 60 and hours at 24; a load outside those ranges
// is stored as given and the next tick wraps any count at or above its limit.
// The response carries six active-low segment bytes, two per digit pair, and
// the hour chime flag, which is set when the tick rolled minutes into a new
// hour. The colon (bit 7 of the minute and second first bytes) and the dots
// (bit 0 of the hour and minute second bytes) follow the single CSR bit
// dots_enable, which resets to 1. The block takes one beat per clock cycle
// while the response side is not holding off: a beat is captured in the
// input register, and from there the counter update and segment lookup
// run in one pass into the response register, which presents a tick's
// response. A held-off response blocks the next tick in the input register,
// and with it every beat behind that tick; loads ahead of it still retire.
// The CSR port is always ready and must be written only while the block
// is idle.
module time_of_day_seven_segment_clock import todclk_pkg::*; (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [4:0] load_hours, [10:5] load_minutes,
                                    // [16:11] load_seconds, [23:17] zero
   input  logic        req_tuser,   // [0] mode: 0 load, 1 tick

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [7:0] seg_hours_a, [15:8] seg_hours_b,
                                    // [23:16] seg_minutes_a, [31:24] seg_minutes_b,
                                    // [39:32] seg_seconds_a, [47:40] seg_seconds_b,
                                    // [48] hour_chime, [55:49] zero

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data     // dots_enable
);

   // Input register.
   logic     in_valid_ff, in_valid_in;
   logic     in_mode_ff;
   time_type in_time_ff;

   // Response register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [55:0] rsp_data_ff;

   logic dots_enable_ff, dots_enable_in;

   logic     advance, tick_fire;
   time_type next_time, cur_time;
   logic     chime;
   logic [7:0] hr_a, hr_b, mn_a, mn_b, sc_a, sc_b;

   // A load retires at once; a tick needs the response register free or
   // being drained in this same cycle.
   assign advance    = in_valid_ff && (!in_mode_ff || !rsp_valid_ff || rsp_tready);
   assign tick_fire  = advance && in_mode_ff;
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   todclk_counter u_counter (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .load      (!in_mode_ff),
      .load_time (in_time_ff),
      .next_time (next_time),
      .chime     (chime),
      .cur_time  (cur_time)
   );

   // Hours carry the dot only, minutes both colon and dot, seconds the colon.
   todclk_encoder u_enc_hours (
      .value       (6'(next_time.hours)),
      .has_colon   (1'b0),
      .has_dot     (1'b1),
      .dots_enable (dots_enable_ff),
      .seg_a       (hr_a),
      .seg_b       (hr_b)
   );

   todclk_encoder u_enc_minutes (
      .value       (next_time.minutes),
      .has_colon   (1'b1),
      .has_dot     (1'b1),
      .dots_enable (dots_enable_ff),
      .seg_a       (mn_a),
      .seg_b       (mn_b)
   );

   todclk_encoder u_enc_seconds (
      .value       (next_time.seconds),
      .has_colon   (1'b1),
      .has_dot     (1'b0),
      .dots_enable (dots_enable_ff),
      .seg_a       (sc_a),
      .seg_b       (sc_b)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end

      rsp_valid_in = rsp_valid_ff;
      if (tick_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      dots_enable_in = dots_enable_ff;
      if (csr_valid) begin
         dots_enable_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         dots_enable_ff <= 1'b1;
      end else begin
         in_valid_ff    <= in_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         dots_enable_ff <= dots_enable_in;
      end
   end

   // Payload registers load only on their own handshakes.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_mode_ff         <= req_tuser;
         in_time_ff.hours   <= req_tdata[4:0];
         in_time_ff.minutes <= req_tdata[10:5];
         in_time_ff.seconds <= req_tdata[16:11];
      end
      if (tick_fire) begin
         rsp_data_ff <= {7'd0, chime, sc_b, sc_a, mn_b, mn_a, hr_b, hr_a};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   // A tick never overwrites a response that has not been taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      tick_fire |-> (!rsp_valid_ff || rsp_tready))
      else $error("tick retired over a pending response");

   // Every tick leaves all three counts in range.
   a_tick_in_range: assert property (@(posedge clock) disable iff (reset)
      tick_fire |=> (cur_time.seconds < 6'd60 && cur_time.minutes < 6'd60
                     && cur_time.hours < 5'd24))
      else $error("counts out of range after a tick");

   // A tick is followed by a valid response beat.
   a_tick_response: assert property (@(posedge clock) disable iff (reset)
      tick_fire |=> rsp_tvalid)
      else $error("tick produced no response");

   // The chime comes only with minutes back at zero.
   a_chime_zero: assert property (@(posedge clock) disable iff (reset)
      (tick_fire && chime) |=> (cur_time.minutes == 6'd0))
      else $error("chime without rollover to the top of the hour");
`endif

endmodule

### test/time_of_day_seven_segment_clock_tb.sv
// Self-checking testbench for the time-of-day seven-segment clock.
// It drives the request, response and CSR streams of the block and predicts
// each segment frame. It needs time_of_day_seven_segment_clock and the files it depends on.
module time_of_day_seven_segment_clock_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Request beat kinds carried in req_tuser.
   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   // A load beat gives no response, so before a CSR write the bench waits out
   // the input register of the block with some margin.
   localparam int SETTLE_CYCLES = 8;
   // Length of the deliberate response hold-off that fills the block.
   localparam int HOLD_CYCLES   = 200;
   // Far above the slowest correct run: about 2000 beats with random gaps and
   // stalls, plus one long hold-off.
   localparam int CYCLE_LIMIT   = 400000;
   localparam int REPORT_LIMIT  = 10;

   // Active-high segment masks are the inverse of these active-low tables.
   localparam logic [7:0] TENS_A [10] = '{
      8'h8F, 8'hEF, 8'hCF, 8'hCF, 8'hAF, 8'h9F, 8'h9F, 8'hCF, 8'h8F, 8'h8F};
   localparam logic [7:0] TENS_B [10] = '{
      8'h1F, 8'hDF, 8'h2F, 8'h8F, 8'hCF, 8'h8F, 8'h0F, 8'hDF, 8'h0F, 8'h8F};
   localparam logic [7:0] ONES_A [10] = '{
      8'hF8, 8'hFE, 8'hF4, 8'hF4, 8'hF2, 8'hF1, 8'hF1, 8'hFC, 8'hF0, 8'hF0};
   localparam logic [7:0] ONES_B [10] = '{
      8'hF1, 8'hFD, 8'hF3, 8'hF9, 8'hFD, 8'hF9, 8'hF1, 8'hFD, 8'hF1, 8'hF9};

   // One response beat, split into its fields.
   typedef struct packed {
      logic [7:0] hours_a;
      logic [7:0] hours_b;
      logic [7:0] minutes_a;
      logic [7:0] minutes_b;
      logic [7:0] seconds_a;
      logic [7:0] seconds_b;
      logic       chime;
   } seg_frame_type;

   // All block inputs start at known values.
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // [4:0] hours, [10:5] minutes, [16:11] seconds
   logic        req_tuser  = 1'b0; // [0] mode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;         // six segment bytes from bit 0 up, [48] chime
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic        csr_data   = 1'b0; // dots_enable

   // Predicted state of the block: the time counters and the CSR bit.
   logic [4:0]  hours_now   = '0;
   logic [5:0]  minutes_now = '0;
   logic [5:0]  seconds_now = '0;
   logic        dots_on     = 1'b1;

   // Frames owed by the block, oldest first.
   seg_frame_type frames_due[$];

   int          errors        = 0;
   int          cycles        = 0;
   bit          idle_on       = 1'b1;
   int          hold_requests = 0;
   int          hold_served   = 0;
   int          hold_left     = 0;
   int          stall_left    = 0;

   time_of_day_seven_segment_clock dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Encodes one digit pair: the tens and ones masks are merged, then the
   // colon and dot bits follow dots_on where the pair has them.
   function automatic logic [15:0] segment_pair(input int value, input bit colon,
                                                input bit dot);
      int         shown;
      int         tens;
      int         ones;
      logic [7:0] lit_a;
      logic [7:0] lit_b;
      shown = (value > 99) ? 99 : value;
      tens  = (shown / 10) % 10;
      ones  = shown % 10;
      lit_a = ~TENS_A[tens] | ~ONES_A[ones];
      lit_b = ~TENS_B[tens] | ~ONES_B[ones];
      if (colon) lit_a[7] = dots_on;
      if (dot) lit_b[0] = dots_on;
      return {~lit_b, ~lit_a};
   endfunction

   // Advances the predicted time by one second and builds the frame. A count
   // that was loaded at or above its limit is treated like a wrap.
   function automatic seg_frame_type advance_time();
      seg_frame_type frame;
      int          h;
      int          m;
      int          s;
      logic [15:0] pair;
      h = hours_now;
      m = minutes_now;
      s = seconds_now + 1;
      frame.chime = 1'b0;
      if (s >= 60) begin
         m = m + 1;
         s = 0;
      end
      if (m >= 60) begin
         h = h + 1;
         frame.chime = 1'b1;
         m = 0;
      end
      if (h >= 24) h = 0;
      hours_now   = 5'(h);
      minutes_now = 6'(m);
      seconds_now = 6'(s);
      pair = segment_pair(h, 1'b0, 1'b1);
      {frame.hours_b, frame.hours_a} = pair;
      pair = segment_pair(m, 1'b1, 1'b1);
      {frame.minutes_b, frame.minutes_a} = pair;
      pair = segment_pair(s, 1'b1, 1'b0);
      {frame.seconds_b, frame.seconds_a} = pair;
      return frame;
   endfunction

   // Offers one request beat, with a random gap in front of it while idling
   // is on, and updates the prediction at the edge that accepts it. Valid
   // stays high afterwards so that back-to-back beats need no toggle.
   task automatic send_beat(input logic mode, input logic [4:0] h,
                            input logic [5:0] m, input logic [5:0] s);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {7'd0, s, m, h};
      do @(posedge clock); while (!req_tready);
      if (mode == MODE_TICK) begin
         frames_due.push_back(advance_time());
      end else begin
         hours_now   = h;
         minutes_now = m;
         seconds_now = s;
      end
   endtask

   task automatic send_tick();
      send_beat(MODE_TICK, 5'($urandom), 6'($urandom), 6'($urandom));
   endtask

   task automatic send_load(input int h, input int m, input int s);
      send_beat(MODE_LOAD, 5'(h), 6'(m), 6'(s));
   endtask

   // Stops offering beats, waits until every owed frame has arrived and then
   // lets the pipeline empty of any trailing load.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (frames_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes dots_enable while the block is idle.
   task automatic write_dots(input logic value);
      settle();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      dots_on = value;
   endtask

   // The first ticks after reset count up from midnight with dots lit.
   task automatic test_reset_state();
      repeat (3) send_tick();
   endtask

   // Every carry path, including counts loaded out of range and a load that
   // replaces another one before any tick.
   task automatic test_rollovers();
      send_load(23, 59, 59);
      send_tick();
      send_load(9, 59, 59);
      send_tick();
      send_tick();
      send_load(19, 9, 59);
      send_tick();
      // All fields at their full width: every counter wraps at once.
      send_load(31, 63, 63);
      send_tick();
      // Hours above range with no carry still return to zero.
      send_load(25, 10, 10);
      send_tick();
      // Minutes above range with no carry still chime.
      send_load(10, 62, 5);
      send_tick();
      send_load(10, 10, 60);
      send_tick();
      send_load(0, 0, 0);
      send_load(12, 34, 56);
      send_tick();
      send_load(0, 0, 0);
      send_tick();
   endtask

   // Blanked colon and dots, then lit again.
   task automatic test_dots_setting();
      write_dots(1'b0);
      send_load(18, 48, 28);
      repeat (3) send_tick();
      write_dots(1'b1);
      repeat (2) send_tick();
   endtask

   // The receiver holds off for a long stretch while ticks keep coming, so
   // the block fills up and must stall its request side.
   task automatic test_full_stall();
      hold_requests <= hold_requests + 1;
      repeat (40) send_tick();
      settle();
   endtask

   // The sender stops mid-stream until every frame has come back.
   task automatic test_drain_pause();
      send_load(22, 59, 40);
      repeat (20) send_tick();
      settle();
      repeat (20) send_tick();
   endtask

   // Mostly ticks, with loads that often land just before a rollover so that
   // the minute and hour carries come up often, and some loads of raw values.
   task automatic random_phase(input int count);
      int pick;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            send_tick();
         end else if (pick < 92) begin
            send_load($urandom_range(0, 23),
                      ($urandom_range(0, 1) != 0) ? 59 : $urandom_range(0, 59),
                      ($urandom_range(0, 1) != 0) ? $urandom_range(50, 59)
                                                   : $urandom_range(0, 59));
         end else begin
            send_beat(MODE_LOAD, 5'($urandom), 6'($urandom), 6'($urandom));
         end
      end
   endtask

   // Random phases under changing dot settings; the last one runs with no
   // idling on either side.
   task automatic test_random();
      for (int phase = 0; phase < 6; phase++) begin
         if (phase == 0) write_dots(1'b0);
         else if (phase == 1) write_dots(1'b1);
         else write_dots(1'($urandom_range(0, 1)));
         if (phase == 5) idle_on <= 1'b0;
         random_phase(300);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_rollovers();
      test_dots_setting();
      test_full_stall();
      test_drain_pause();
      test_random();
      settle();
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Response-side backpressure: the long hold-off when the test asks for
   // one, otherwise short random stalls while idling is on.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_served != hold_requests) begin
         hold_served = hold_served + 1;
         hold_left   = HOLD_CYCLES - 1;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 5) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Each accepted response beat is compared field by field with the oldest
   // owed frame; a beat with nothing owed is an error too.
   always @(posedge clock) begin : check_frames
      seg_frame_type want;
      seg_frame_type got;
      logic [7:0] want_f [7];
      logic [7:0] got_f [7];
      string      names [7];
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16],
                rsp_tdata[31:24], rsp_tdata[39:32], rsp_tdata[47:40], rsp_tdata[48]};
         if (frames_due.size() == 0) begin
            if (errors < REPORT_LIMIT)
               $display("unexpected response beat: tdata %h", rsp_tdata);
            errors = errors + 1;
         end else begin
            want = frames_due.pop_front();
            names  = '{"seg_hours_a", "seg_hours_b", "seg_minutes_a", "seg_minutes_b",
                       "seg_seconds_a", "seg_seconds_b", "hour_chime"};
            want_f = '{want.hours_a, want.hours_b, want.minutes_a, want.minutes_b,
                       want.seconds_a, want.seconds_b, {7'd0, want.chime}};
            got_f  = '{got.hours_a, got.hours_b, got.minutes_a, got.minutes_b,
                       got.seconds_a, got.seconds_b, {7'd0, got.chime}};
            for (int i = 0; i < 7; i++) begin
               if (got_f[i] !== want_f[i]) begin
                  if (errors < REPORT_LIMIT)
                     $display("mismatch in %s: expected %h, got %h",
                              names[i], want_f[i], got_f[i]);
                  errors = errors + 1;
               end
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles = cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

endmodule

### filelist.f
design/todclk_pkg.sv
design/todclk_counter.sv
design/todclk_encoder.sv
design/time_of_day_seven_segment_clock.sv
test/time_of_day_seven_segment_clock_tb.sv
